// ----- rtl/pthb_pkg.sv -----
package pthb_pkg;

    localparam int TABLE_ENTRIES = 4;
    localparam int MAX_RESULTS   = 4;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int FOUND_W       = $clog2(MAX_RESULTS);
    localparam int OP_W          = 2;
    localparam int ADDR_W        = 32;
    localparam int TIME_W        = 32;
    localparam int WIN_W         = 16;
    localparam int SLOT_W        = 2;
    localparam int ALIVE_W       = 3;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_HEARD  = 2'd0,
        OP_AGE    = 2'd1,
        OP_FANOUT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EMIT_HEARD = 2'd0,
        EMIT_COUNT = 2'd1,
        EMIT_DEST  = 2'd2,
        EMIT_NONE  = 2'd3
    } emit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_VICTIM,
        ST_WRITE,
        ST_AGE,
        ST_COUNT,
        ST_MARK,
        ST_FAN
    } state_t;

    typedef struct packed {
        logic  load;
        logic  idx_clr;
        logic  idx_step;
        logic  match_set;
        logic  victim_set;
        logic  age_step;
        logic  mark_step;
        logic  tab_write;
        logic  found_inc;
        logic  emit;
        emit_t emit_kind;
    } cmd_t;

    typedef struct packed {
        logic addr_eq;
        logic stamp_zero;
        logic age_gt_best;
        logic idx_first;
        logic idx_last;
        logic out_free;
        logic mask_any;
        logic mask_cur;
        logic run_end;
    } status_t;

endpackage

// ----- rtl/peer_table_with_heartbeat_aging.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------------
// input    | s_valid / s_ready     | s_operation, s_peer_address, s_now_ms
// result   | m_valid / m_ready     | m_hit, m_slot, m_alive_count, m_dest_address,
//          |                       | m_dest_valid, m_last_of_run
// config   | cfg_wr_en             | cfg_wr_data (heartbeat window, ms)
//
// One item at a time; the table is scanned one slot per cycle.
// Heard: accept, match scan, victim scan if no match (first free slot, else oldest), then write.
// Age: accept, scan every slot, then result. Fan-out: accept, mark alive slots, then one result per alive slot.
// A full result register holds the scan in place until m_ready frees it.
// aresetn (synchronous) clears the table to all free and the window to 1000.
module peer_table_with_heartbeat_aging
    import pthb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [WIN_W-1:0]   cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_operation,
    input  logic [ADDR_W-1:0]  s_peer_address,
    input  logic [TIME_W-1:0]  s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [SLOT_W-1:0]  m_slot,
    output logic [ALIVE_W-1:0] m_alive_count,
    output logic [ADDR_W-1:0]  m_dest_address,
    output logic               m_dest_valid,
    output logic               m_last_of_run
);

    cmd_t    cmd;
    status_t status;

    pthb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .status      (status),
        .cmd         (cmd)
    );

    pthb_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_peer_address (s_peer_address),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_slot         (m_slot),
        .m_alive_count  (m_alive_count),
        .m_dest_address (m_dest_address),
        .m_dest_valid   (m_dest_valid),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

// ----- rtl/pthb_ctrl.sv -----
module pthb_ctrl
    import pthb_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [OP_W-1:0] s_operation,
    input  status_t         status,
    output cmd_t            cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.emit_kind = EMIT_HEARD;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    case (s_operation)
                        OP_HEARD:  state_next = ST_MATCH;
                        OP_AGE:    state_next = ST_AGE;
                        OP_FANOUT: state_next = ST_MARK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MATCH: begin
                if (status.addr_eq) begin
                    cmd.match_set = 1'b1;
                    state_next    = ST_WRITE;
                end else if (status.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_VICTIM;
                end else begin
                    cmd.idx_step = 1'b1;
                end
            end
            ST_VICTIM: begin
                if (status.stamp_zero) begin
                    cmd.victim_set = 1'b1;
                    state_next     = ST_WRITE;
                end else begin
                    cmd.victim_set = status.idx_first || status.age_gt_best;
                    if (status.idx_last) begin
                        state_next = ST_WRITE;
                    end else begin
                        cmd.idx_step = 1'b1;
                    end
                end
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    cmd.tab_write = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_HEARD;
                    state_next    = ST_IDLE;
                end
            end
            ST_AGE: begin
                cmd.age_step = 1'b1;
                if (status.idx_last) begin
                    state_next = ST_COUNT;
                end else begin
                    cmd.idx_step = 1'b1;
                end
            end
            ST_COUNT: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_COUNT;
                    state_next    = ST_IDLE;
                end
            end
            ST_MARK: begin
                cmd.mark_step = 1'b1;
                if (status.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_FAN;
                end else begin
                    cmd.idx_step = 1'b1;
                end
            end
            ST_FAN: begin
                if (!status.mask_any) begin
                    if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EMIT_NONE;
                        state_next    = ST_IDLE;
                    end
                end else if (status.mask_cur) begin
                    if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EMIT_DEST;
                        cmd.found_inc = 1'b1;
                        if (status.run_end) begin
                            state_next = ST_IDLE;
                        end else begin
                            cmd.idx_step = 1'b1;
                        end
                    end
                end else begin
                    cmd.idx_step = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/pthb_dp.sv -----
module pthb_dp
    import pthb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic                cfg_wr_en,
    input  logic [WIN_W-1:0]    cfg_wr_data,
    input  logic [ADDR_W-1:0]   s_peer_address,
    input  logic [TIME_W-1:0]   s_now_ms,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic [SLOT_W-1:0]   m_slot,
    output logic [ALIVE_W-1:0]  m_alive_count,
    output logic [ADDR_W-1:0]   m_dest_address,
    output logic                m_dest_valid,
    output logic                m_last_of_run
);

    logic [ADDR_W-1:0]        addr_tab_reg [TABLE_ENTRIES];
    logic [TIME_W-1:0]        stamp_tab_reg [TABLE_ENTRIES];
    logic [WIN_W-1:0]         window_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [TIME_W-1:0]        now_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         target_reg;
    logic                     hit_reg;
    logic [TIME_W-1:0]        best_age_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [TABLE_ENTRIES-1:0] mask_reg;
    logic [FOUND_W-1:0]       found_reg;

    logic                     out_valid_reg;
    logic                     out_hit_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    logic [ALIVE_W-1:0]       out_count_reg;
    logic [ADDR_W-1:0]        out_dest_reg;
    logic                     out_dest_valid_reg;
    logic                     out_last_reg;

    logic                     out_hit_next;
    logic [SLOT_W-1:0]        out_slot_next;
    logic [ALIVE_W-1:0]       out_count_next;
    logic [ADDR_W-1:0]        out_dest_next;
    logic                     out_dest_valid_next;
    logic                     out_last_next;

    logic [ADDR_W-1:0]        cur_addr;
    logic [TIME_W-1:0]        cur_stamp;
    logic [TIME_W-1:0]        cur_age;
    logic                     cur_alive;
    logic                     higher_alive;

    assign cur_addr     = addr_tab_reg[idx_reg];
    assign cur_stamp    = stamp_tab_reg[idx_reg];
    assign cur_age      = now_reg - cur_stamp;
    assign cur_alive    = (cur_stamp != '0) && (cur_age < TIME_W'(window_reg));
    assign higher_alive = ((mask_reg >> idx_reg) >> 1) != '0;

    always_comb begin
        status.addr_eq     = (cur_addr == addr_reg);
        status.stamp_zero  = (cur_stamp == '0);
        status.age_gt_best = (cur_age > best_age_reg);
        status.idx_first   = (idx_reg == '0);
        status.idx_last    = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
        status.out_free    = !out_valid_reg || m_ready;
        status.mask_any    = (mask_reg != '0);
        status.mask_cur    = mask_reg[idx_reg];
        status.run_end     = !higher_alive || (found_reg == FOUND_W'(MAX_RESULTS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                addr_tab_reg[i]  <= '0;
                stamp_tab_reg[i] <= '0;
            end
        end else begin
            if (cmd.tab_write) begin
                addr_tab_reg[target_reg]  <= addr_reg;
                stamp_tab_reg[target_reg] <= now_reg;
            end
            if (cmd.age_step && !cur_alive) begin
                stamp_tab_reg[idx_reg] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= s_peer_address;
            now_reg  <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            target_reg   <= '0;
            hit_reg      <= 1'b0;
            best_age_reg <= '0;
            count_reg    <= '0;
            mask_reg     <= '0;
            found_reg    <= '0;
        end else begin
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_step) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.load) begin
                hit_reg   <= 1'b0;
                count_reg <= '0;
                mask_reg  <= '0;
                found_reg <= '0;
            end
            if (cmd.match_set) begin
                target_reg <= idx_reg;
                hit_reg    <= 1'b1;
            end
            if (cmd.victim_set) begin
                target_reg   <= idx_reg;
                best_age_reg <= cur_age;
            end
            if (cmd.age_step && cur_alive) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.mark_step) begin
                mask_reg[idx_reg] <= cur_alive;
            end
            if (cmd.found_inc) begin
                found_reg <= found_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        out_hit_next        = 1'b0;
        out_slot_next       = '0;
        out_count_next      = '0;
        out_dest_next       = '0;
        out_dest_valid_next = 1'b0;
        out_last_next       = 1'b1;
        case (cmd.emit_kind)
            EMIT_HEARD: begin
                out_hit_next  = hit_reg;
                out_slot_next = SLOT_W'(target_reg);
            end
            EMIT_COUNT: begin
                out_count_next = ALIVE_W'(count_reg);
            end
            EMIT_DEST: begin
                out_slot_next       = SLOT_W'(idx_reg);
                out_dest_next       = cur_addr;
                out_dest_valid_next = 1'b1;
                out_last_next       = status.run_end;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_hit_reg        <= out_hit_next;
            out_slot_reg       <= out_slot_next;
            out_count_reg      <= out_count_next;
            out_dest_reg       <= out_dest_next;
            out_dest_valid_reg <= out_dest_valid_next;
            out_last_reg       <= out_last_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_hit          = out_hit_reg;
    assign m_slot         = out_slot_reg;
    assign m_alive_count  = out_count_reg;
    assign m_dest_address = out_dest_reg;
    assign m_dest_valid   = out_dest_valid_reg;
    assign m_last_of_run  = out_last_reg;

endmodule
